// ----- src/md4_message_digest_macros.svh -----
// ----------------------------------------------------------------------------
// MD4 message digest assertion macros
// Shared concurrent assertion forms for the checker of the digest block.
// ----------------------------------------------------------------------------
`ifndef MD4_MESSAGE_DIGEST_MACROS_SVH
`define MD4_MESSAGE_DIGEST_MACROS_SVH

// Checked only outside reset.
`define MD4_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MD4_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/md4_pkg.sv -----
// ----------------------------------------------------------------------------
// MD4 package
// Types, constants and round helper functions shared by the MD4 modules.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam logic [31:0] MD4_IV_A = 32'h67452301;
    localparam logic [31:0] MD4_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD4_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD4_IV_D = 32'h10325476;
    localparam logic [31:0] MD4_K2   = 32'h5A827999;
    localparam logic [31:0] MD4_K3   = 32'h6ED9EBA1;

    localparam logic [5:0] ROUND_LAST  = 6'd47;
    localparam logic [1:0] DIGEST_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LENLO,
        ST_LENHI,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } md4_state_t;

    typedef enum logic [2:0] {
        PUSH_DATA,
        PUSH_PAD80,
        PUSH_ZERO,
        PUSH_LEN_LO,
        PUSH_LEN_HI
    } push_sel_t;

    typedef struct packed {
        logic       push;
        push_sel_t  push_sel;
        logic       count_len;
        logic       load_work;
        logic       round;
        logic [5:0] step;
        logic       add_chain;
        logic       init_chain;
        logic [1:0] digest_idx;
    } md4_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_pad;
        logic in_last;
        logic in_full;
    } md4_status_t;

    function automatic logic [31:0] md4_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    function automatic logic [4:0] md4_shift(input logic [1:0] rnd, input logic [1:0] j);
        logic [4:0] s;
        case (rnd)
            2'd0:
            begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd7;
                    2'd2: s = 5'd11;
                    default: s = 5'd19;
                endcase
            end
            2'd1:
            begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd5;
                    2'd2: s = 5'd9;
                    default: s = 5'd13;
                endcase
            end
            default:
            begin
                case (j)
                    2'd0: s = 5'd3;
                    2'd1: s = 5'd9;
                    2'd2: s = 5'd11;
                    default: s = 5'd15;
                endcase
            end
        endcase
        return s;
    endfunction

    // Message word order: straight in round one, transposed 4x4 in round
    // two, bit-reversed in round three.
    function automatic logic [3:0] md4_msg_index(input logic [1:0] rnd, input logic [3:0] j);
        logic [3:0] idx;
        case (rnd)
            2'd0: idx = j;
            2'd1: idx = {j[1:0], j[3:2]};
            default: idx = {j[0], j[1], j[2], j[3]};
        endcase
        return idx;
    endfunction

endpackage

// ----- src/md4_ctrl.sv -----
// ----------------------------------------------------------------------------
// MD4 controller
// State machine that sequences word loading, padding, compression and output.
// ----------------------------------------------------------------------------
module md4_ctrl
    import md4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        digest_last,
    input  md4_status_t stat,
    output md4_cmd_t    cmd
);

    md4_state_t state_reg, state_next;
    md4_state_t resume_reg, resume_next;
    logic [5:0] step_reg, step_next;
    logic [1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            step_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
        end
    end

    always_comb
    begin
        md4_state_t target;
        logic       do_push;

        target      = ST_IDLE;
        do_push     = 1'b0;
        state_next  = state_reg;
        resume_next = resume_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.push_sel   = PUSH_DATA;
        cmd.step       = step_reg;
        cmd.digest_idx = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    do_push       = 1'b1;
                    cmd.push_sel  = PUSH_DATA;
                    cmd.count_len = 1'b1;
                    if (!stat.in_last)
                        target = ST_IDLE;
                    else if (stat.in_full)
                        target = ST_PAD80;
                    else
                        target = ST_PADZ;
                end
            end
            ST_PAD80:
            begin
                do_push      = 1'b1;
                cmd.push_sel = PUSH_PAD80;
                target       = ST_PADZ;
            end
            ST_PADZ:
            begin
                if (stat.fill_pad)
                    state_next = ST_LENLO;
                else
                begin
                    do_push      = 1'b1;
                    cmd.push_sel = PUSH_ZERO;
                    target       = ST_PADZ;
                end
            end
            ST_LENLO:
            begin
                do_push      = 1'b1;
                cmd.push_sel = PUSH_LEN_LO;
                target       = ST_LENHI;
            end
            ST_LENHI:
            begin
                do_push      = 1'b1;
                cmd.push_sel = PUSH_LEN_HI;
                target       = ST_OUT;
            end
            ST_COMP:
            begin
                cmd.round = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == ROUND_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                state_next    = resume_reg;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == DIGEST_LAST)
                    begin
                        cmd.init_chain = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A push that fills the sixteenth slot starts a compression and
        // returns to the intended state afterward.
        if (do_push)
        begin
            cmd.push = 1'b1;
            if (stat.fill_full)
            begin
                cmd.load_work = 1'b1;
                step_next     = '0;
                resume_next   = target;
                state_next    = ST_COMP;
            end
            else
            begin
                state_next = target;
            end
        end
    end

    assign digest_last = (idx_reg == DIGEST_LAST);

endmodule

// ----- src/md4_dpath.sv -----
// ----------------------------------------------------------------------------
// MD4 datapath
// Word buffer, bit length, chaining value and the one-step-per-cycle round.
// ----------------------------------------------------------------------------
module md4_dpath
    import md4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    input  md4_cmd_t    cmd,
    output md4_status_t stat,
    output logic [31:0] digest_word
);

    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] buf_reg [16];
    logic [3:0]  fill_reg;
    logic [63:0] len_reg;

    logic [2:0]  n_sat;
    logic [31:0] last_word;
    logic [31:0] push_word;
    logic [63:0] len_add;
    logic [1:0]  rnd;
    logic [3:0]  j;
    logic [31:0] f_val, k_val, x_val, sum_val, t_val;

    assign n_sat = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

    // Bytes below the count are kept, the byte at the count becomes the
    // 0x80 pad marker and the bytes above it are cleared.
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (3'(b) < n_sat)
                last_word[8*b +: 8] = data_word[8*b +: 8];
            else if (3'(b) == n_sat)
                last_word[8*b +: 8] = 8'h80;
            else
                last_word[8*b +: 8] = 8'h00;
        end
    end

    always_comb
    begin
        case (cmd.push_sel)
            PUSH_DATA:   push_word = last ? last_word : data_word;
            PUSH_PAD80:  push_word = 32'h0000_0080;
            PUSH_LEN_LO: push_word = len_reg[31:0];
            PUSH_LEN_HI: push_word = len_reg[63:32];
            default:     push_word = '0;
        endcase
    end

    assign len_add = last ? {58'd0, n_sat, 3'd0} : 64'd32;

    assign rnd = cmd.step[5:4];
    assign j   = cmd.step[3:0];

    always_comb
    begin
        case (rnd)
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = '0;
            end
            2'd1:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = MD4_K2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = MD4_K3;
            end
        endcase
    end

    assign x_val   = buf_reg[md4_msg_index(rnd, j)];
    assign sum_val = a_reg + f_val + x_val + k_val;
    assign t_val   = md4_rotl(sum_val, md4_shift(rnd, j[1:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            buf_reg[fill_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= MD4_IV_A;
            chain_reg[1] <= MD4_IV_B;
            chain_reg[2] <= MD4_IV_C;
            chain_reg[3] <= MD4_IV_D;
            a_reg        <= '0;
            b_reg        <= '0;
            c_reg        <= '0;
            d_reg        <= '0;
            fill_reg     <= '0;
            len_reg      <= '0;
        end
        else
        begin
            if (cmd.push)
                fill_reg <= fill_reg + 4'd1;
            if (cmd.count_len)
                len_reg <= len_reg + len_add;
            else if (cmd.init_chain)
                len_reg <= '0;

            if (cmd.load_work)
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
            end
            else if (cmd.round)
            begin
                a_reg <= d_reg;
                b_reg <= t_val;
                c_reg <= b_reg;
                d_reg <= c_reg;
            end

            if (cmd.add_chain)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            else if (cmd.init_chain)
            begin
                chain_reg[0] <= MD4_IV_A;
                chain_reg[1] <= MD4_IV_B;
                chain_reg[2] <= MD4_IV_C;
                chain_reg[3] <= MD4_IV_D;
            end
        end
    end

    assign stat.fill_full = (fill_reg == 4'd15);
    assign stat.fill_pad  = (fill_reg == 4'd14);
    assign stat.in_last   = last;
    assign stat.in_full   = (n_sat == 3'd4);

    assign digest_word = chain_reg[cmd.digest_idx];

endmodule

// ----- src/md4_message_digest.sv -----
// ----------------------------------------------------------------------------
// MD4 message digest
// Streaming MD4 hash: 32-bit little-endian message words in, four digest words out.
// ----------------------------------------------------------------------------
// A word that does not complete a block is taken while the controller is idle.
// The word that fills a block of sixteen starts a compression: the MD4 round
// steps, then the add into the chaining value; no word is taken until it ends.
// A last word runs padding (one pad word per cycle, held while a filled block
// compresses) and one or two compressions before the first digest word.
// Reset is asynchronous and active low: it loads the MD4 initial values and
// clears the fill count, bit length and controller state.
// ----------------------------------------------------------------------------
module md4_message_digest
    import md4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        digest_last
);

    // The controller owns every handshake and the sequencing: it accepts
    // a word only while idle, walks through the padding words after a last
    // word, and runs the 48-step round counter whenever the buffer fills.
    // The datapath holds the sixteen-word buffer, the 64-bit bit length, the
    // working registers A..D and the chaining value, and performs one MD4
    // step per cycle under the controller's command.
    md4_cmd_t    cmd;
    md4_status_t stat;

    md4_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_last (digest_last),
        .stat        (stat),
        .cmd         (cmd)
    );

    // The digest words are read straight from the chaining registers, which
    // stay unchanged while a word waits on the output side.
    md4_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (digest_word)
    );

endmodule

// ----- src/md4_checker.sv -----
// ----------------------------------------------------------------------------
// MD4 port checker
// Watches the digest block's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "md4_message_digest_macros.svh"

module md4_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] data_word,
    input logic [2:0]  valid_bytes,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic        digest_last
);

    `MD4_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(digest_last), "stalled digest word changed")
    `MD4_ASSERT(a_no_overlap, !(in_ready && out_valid), "input taken while digest is shown")
    `MD4_ASSERT(a_last_ends, out_valid && out_ready && digest_last |=> !out_valid, "digest output ran past the final word")
    `MD4_ASSERT(a_plain_word, in_valid && in_ready && !last |=> !out_valid, "digest shown after a word that is not last")
    `MD4_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind md4_message_digest md4_checker u_md4_checker (.*);
